// File: sv/dd_pkg.sv
// ----------------------------------------------------------------------------
// dd_pkg: shared types and constants of the deadlock detector
// Sizes of the stores, field widths, mode codes and the structs that pass
// between the top level and the detection core.
// ----------------------------------------------------------------------------
package dd_pkg;

   // store geometry
   localparam int MAX_PROCESSES = 16;
   localparam int MAX_RESOURCES = 8;
   localparam int COUNT_BITS    = 8;

   localparam int PIDX_BITS = $clog2(MAX_PROCESSES);
   localparam int RIDX_BITS = $clog2(MAX_RESOURCES);
   localparam int ADDR_BITS = PIDX_BITS + RIDX_BITS;
   localparam int MAT_DEPTH = MAX_PROCESSES * MAX_RESOURCES;

   // work entries hold the available count plus every allocation
   localparam int WORK_BITS = COUNT_BITS + $clog2(MAX_PROCESSES + 1);

   // configuration registers
   localparam int PC_BITS       = 5;
   localparam int RC_BITS       = 4;
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PROCESS_COUNT  = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RESOURCE_COUNT = 1'd1;
   localparam logic [PC_BITS-1:0] PC_RESET = PC_BITS'(MAX_PROCESSES);
   localparam logic [RC_BITS-1:0] RC_RESET = RC_BITS'(MAX_RESOURCES);

   // request modes
   localparam int MODE_BITS = 2;
   localparam logic [MODE_BITS-1:0] MODE_MATRIX    = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_AVAILABLE = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_DETECT    = 2'd2;

   // one matrix cell: allocation and request side by side
   typedef struct packed {
      logic [COUNT_BITS-1:0] held;
      logic [COUNT_BITS-1:0] requested;
   } dd_entry_type;

   // load and start commands from the top level to the core
   typedef struct packed {
      logic                  mat_we;
      logic                  avail_we;
      logic                  start;
      logic [PIDX_BITS-1:0]  pidx;
      logic [RIDX_BITS-1:0]  ridx;
      dd_entry_type          entry;
      logic [COUNT_BITS-1:0] avail;
      logic [PC_BITS-1:0]    process_count;
      logic [RC_BITS-1:0]    resource_count;
   } dd_cmd_type;

   // one result from the core
   typedef struct packed {
      logic                 valid;
      logic [PIDX_BITS-1:0] process_id;
      logic                 deadlocked;
      logic                 any_deadlock;
      logic                 last;
   } dd_result_type;

endpackage

// File: sv/dd_if.sv
// ----------------------------------------------------------------------------
// dd_if: request and response channels of the deadlock detector
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface dd_req_if
   import dd_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [MODE_BITS-1:0]  mode;
   logic [PIDX_BITS-1:0]  process_index;
   logic [RIDX_BITS-1:0]  resource_index;
   logic [COUNT_BITS-1:0] held_count;
   logic [COUNT_BITS-1:0] requested_count;
   logic [COUNT_BITS-1:0] available_count;

   modport source (
      output valid, mode, process_index, resource_index,
             held_count, requested_count, available_count,
      input  ready
   );
   modport sink (
      input  valid, mode, process_index, resource_index,
             held_count, requested_count, available_count,
      output ready
   );
endinterface

interface dd_rsp_if
   import dd_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [PIDX_BITS-1:0] process_id;
   logic                 deadlocked;
   logic                 any_deadlock;
   logic                 last;

   modport source (
      output valid, process_id, deadlocked, any_deadlock, last,
      input  ready
   );
   modport sink (
      input  valid, process_id, deadlocked, any_deadlock, last,
      output ready
   );
endinterface

// File: sv/dd_core.sv
// ----------------------------------------------------------------------------
// dd_core: matrix stores and detection sequencer
// Holds the allocation/request memory, available and work vectors and the
// finished flags. A small sequencer walks the matrix one cell per step with
// a single compare/add unit, then hands out one result per process.
// ----------------------------------------------------------------------------
module dd_core
   import dd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  dd_cmd_type    cmd,
   input  logic          take,
   output logic          idle,
   output dd_result_type result
);

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_INIT  = 3'd1;
   localparam logic [2:0] ST_CHECK = 3'd2;
   localparam logic [2:0] ST_ADD   = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [PIDX_BITS-1:0] p_ff, p_in;
   logic [RIDX_BITS-1:0] r_ff, r_in;
   logic [PIDX_BITS-1:0] pass_ff, pass_in;
   logic                 fetch_ff, fetch_in;
   logic                 nz_ff, nz_in;
   logic [PIDX_BITS-1:0] np_last_ff, np_last_in;
   logic [RIDX_BITS-1:0] nr_last_ff, nr_last_in;
   logic [WORK_BITS-1:0] work_ff [MAX_RESOURCES];
   logic [WORK_BITS-1:0] work_in [MAX_RESOURCES];
   logic [MAX_PROCESSES-1:0] fin_ff, fin_in;

   dd_entry_type          mat_mem [MAT_DEPTH];
   dd_entry_type          rd_ff;
   logic [COUNT_BITS-1:0] avail_mem [MAX_RESOURCES];

   logic [PC_BITS-1:0]       pc_sel;
   logic [RC_BITS-1:0]       rc_sel;
   logic                     p_end, r_end, pass_end;
   logic                     advance;
   logic [WORK_BITS-1:0]     req_ext, alloc_ext, work_cur;
   logic [MAX_PROCESSES-1:0] in_use;

   // matrix memory: one write port for loads, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.mat_we) begin
         mat_mem[{cmd.pidx, cmd.ridx}] <= cmd.entry;
      end
      if (cmd.avail_we) begin
         avail_mem[cmd.ridx] <= cmd.avail;
      end
      rd_ff <= mat_mem[{p_ff, r_ff}];
   end

   // clamp the counts to the range 1 to the store size
   always_comb begin
      if (cmd.process_count == '0) begin
         pc_sel = PC_BITS'(1);
      end else if (cmd.process_count > PC_BITS'(MAX_PROCESSES)) begin
         pc_sel = PC_BITS'(MAX_PROCESSES);
      end else begin
         pc_sel = cmd.process_count;
      end
      if (cmd.resource_count == '0) begin
         rc_sel = RC_BITS'(1);
      end else if (cmd.resource_count > RC_BITS'(MAX_RESOURCES)) begin
         rc_sel = RC_BITS'(MAX_RESOURCES);
      end else begin
         rc_sel = cmd.resource_count;
      end
   end

   assign p_end    = (p_ff == np_last_ff);
   assign r_end    = (r_ff == nr_last_ff);
   assign pass_end = (pass_ff == np_last_ff);

   // shared compare/add operands
   assign req_ext   = WORK_BITS'(rd_ff.requested);
   assign alloc_ext = WORK_BITS'(rd_ff.held);
   assign work_cur  = work_ff[r_ff];

   // sequencer
   always_comb begin
      state_in   = state_ff;
      p_in       = p_ff;
      r_in       = r_ff;
      pass_in    = pass_ff;
      fetch_in   = 1'b0;
      nz_in      = nz_ff;
      np_last_in = np_last_ff;
      nr_last_in = nr_last_ff;
      work_in    = work_ff;
      fin_in     = fin_ff;
      advance    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               np_last_in = PIDX_BITS'(pc_sel - PC_BITS'(1));
               nr_last_in = RIDX_BITS'(rc_sel - RC_BITS'(1));
               p_in       = '0;
               r_in       = '0;
               nz_in      = 1'b0;
               fetch_in   = 1'b1;
               state_in   = ST_INIT;
            end
         end
         // copy available into work, mark processes holding nothing
         ST_INIT: begin
            if (!fetch_ff) begin
               if (p_ff == '0) begin
                  work_in[r_ff] = WORK_BITS'(avail_mem[r_ff]);
               end
               fetch_in = 1'b1;
               if (r_end) begin
                  fin_in[p_ff] = !(nz_ff || (rd_ff.held != '0));
                  nz_in        = 1'b0;
                  r_in         = '0;
                  if (p_end) begin
                     p_in     = '0;
                     pass_in  = '0;
                     state_in = ST_CHECK;
                  end else begin
                     p_in = p_ff + PIDX_BITS'(1);
                  end
               end else begin
                  nz_in = nz_ff || (rd_ff.held != '0);
                  r_in  = r_ff + RIDX_BITS'(1);
               end
            end
         end
         // every request of the process must fit within work
         ST_CHECK: begin
            if (fin_ff[p_ff]) begin
               advance = 1'b1;
            end else if (!fetch_ff) begin
               if (req_ext > work_cur) begin
                  advance = 1'b1;
               end else if (r_end) begin
                  r_in     = '0;
                  fetch_in = 1'b1;
                  state_in = ST_ADD;
               end else begin
                  r_in     = r_ff + RIDX_BITS'(1);
                  fetch_in = 1'b1;
               end
            end
         end
         // release the allocation of a finished process
         ST_ADD: begin
            if (!fetch_ff) begin
               work_in[r_ff] = work_cur + alloc_ext;
               if (r_end) begin
                  fin_in[p_ff] = 1'b1;
                  advance      = 1'b1;
               end else begin
                  r_in     = r_ff + RIDX_BITS'(1);
                  fetch_in = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (take) begin
               if (p_end) begin
                  p_in     = '0;
                  state_in = ST_IDLE;
               end else begin
                  p_in = p_ff + PIDX_BITS'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // step to the next process, to the next pass after the last process, and to the results after the last pass
      if (advance) begin
         r_in     = '0;
         fetch_in = 1'b1;
         state_in = ST_CHECK;
         if (p_end) begin
            p_in = '0;
            if (pass_end) begin
               fetch_in = 1'b0;
               state_in = ST_EMIT;
            end else begin
               pass_in = pass_ff + PIDX_BITS'(1);
            end
         end else begin
            p_in = p_ff + PIDX_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         p_ff     <= '0;
         r_ff     <= '0;
         pass_ff  <= '0;
         fetch_ff <= 1'b0;
         nz_ff    <= 1'b0;
         fin_ff   <= '0;
         for (int i = 0; i < MAX_RESOURCES; i++) begin
            work_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         p_ff     <= p_in;
         r_ff     <= r_in;
         pass_ff  <= pass_in;
         fetch_ff <= fetch_in;
         nz_ff    <= nz_in;
         fin_ff   <= fin_in;
         work_ff  <= work_in;
      end
   end

   always_ff @(posedge clock) begin
      np_last_ff <= np_last_in;
      nr_last_ff <= nr_last_in;
   end

   // processes in use, for the summary flag
   always_comb begin
      for (int i = 0; i < MAX_PROCESSES; i++) begin
         in_use[i] = (PIDX_BITS'(i) <= np_last_ff);
      end
   end

   assign idle                = (state_ff == ST_IDLE);
   assign result.valid        = (state_ff == ST_EMIT);
   assign result.process_id   = p_ff;
   assign result.deadlocked   = !fin_ff[p_ff];
   assign result.any_deadlock = |(~fin_ff & in_use);
   assign result.last         = p_end;

   // checks
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> (state_ff == ST_IDLE))
      else $error("detect started while busy");

   a_emit_range: assert property (@(posedge clock) disable iff (reset)
      result.valid |-> (p_ff <= np_last_ff))
      else $error("result for a process not in use");

   a_last_done: assert property (@(posedge clock) disable iff (reset)
      (result.valid && take && result.last) |=> (state_ff == ST_IDLE))
      else $error("sequencer did not return to idle after last result");

   a_fetch_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_EMIT) |-> !fetch_ff)
      else $error("matrix fetch pending outside the sweep");

   a_emit_flags: assert property (@(posedge clock) disable iff (reset)
      (result.valid && !take) |=> $stable(fin_ff))
      else $error("finished flags moved while results are pending");

endmodule

// File: sv/deadlock_detector_unit.sv
// ----------------------------------------------------------------------------
// deadlock_detector_unit: multi-instance deadlock detection
// Load items fill the allocation/request matrix and the available vector; a
// detect item runs the detection and returns one result per process in use.
// ----------------------------------------------------------------------------
// Load items (matrix or available entry) are accepted back to back. A detect
// item keeps the request side busy while the sequencer walks the matrix memory
// through its one registered read port, where each cell read takes an address
// and then registered data: a setup sweep over all cells in use, then P passes
// over P processes with the request check, the release of the allocation of a
// process that finishes (once per process), a skip for each finished process,
// and finally P result transfers at one per cycle while the response side is
// ready (P = processes in use).
// ----------------------------------------------------------------------------
module deadlock_detector_unit
   import dd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   dd_req_if.sink                   req_ch,
   dd_rsp_if.source                 rsp_ch,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   logic [PC_BITS-1:0] process_count_ff;
   logic [RC_BITS-1:0] resource_count_ff;

   dd_cmd_type    cmd;
   dd_result_type result;
   logic          core_idle;
   logic          req_xfer;
   logic          take;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PIDX_BITS-1:0] rsp_pid_ff;
   logic                 rsp_dead_ff, rsp_any_ff, rsp_last_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         process_count_ff  <= PC_RESET;
         resource_count_ff <= RC_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PROCESS_COUNT: begin
               process_count_ff <= csr_wdata[PC_BITS-1:0];
            end
            CSR_RESOURCE_COUNT: begin
               resource_count_ff <= csr_wdata[RC_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // request decode
   assign req_ch.ready = core_idle;
   assign req_xfer     = req_ch.valid && req_ch.ready;

   always_comb begin
      cmd.mat_we          = req_xfer && (req_ch.mode == MODE_MATRIX);
      cmd.avail_we        = req_xfer && (req_ch.mode == MODE_AVAILABLE);
      cmd.start           = req_xfer && (req_ch.mode == MODE_DETECT);
      cmd.pidx            = req_ch.process_index;
      cmd.ridx            = req_ch.resource_index;
      cmd.entry.held      = req_ch.held_count;
      cmd.entry.requested = req_ch.requested_count;
      cmd.avail           = req_ch.available_count;
      cmd.process_count   = process_count_ff;
      cmd.resource_count  = resource_count_ff;
   end

   dd_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .take   (take),
      .idle   (core_idle),
      .result (result)
   );

   // output register: refilled when empty or on a transfer
   assign take = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && result.valid) begin
         rsp_pid_ff  <= result.process_id;
         rsp_dead_ff <= result.deadlocked;
         rsp_any_ff  <= result.any_deadlock;
         rsp_last_ff <= result.last;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.process_id   = rsp_pid_ff;
   assign rsp_ch.deadlocked   = rsp_dead_ff;
   assign rsp_ch.any_deadlock = rsp_any_ff;
   assign rsp_ch.last         = rsp_last_ff;

   // checks
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |=> rsp_valid_ff)
      else $error("pending result dropped");

   a_busy_no_req: assert property (@(posedge clock) disable iff (reset)
      result.valid |-> !req_ch.ready)
      else $error("request side open while results are produced");

   a_last_any: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_dead_ff) |-> rsp_any_ff)
      else $error("deadlocked process without summary flag");

endmodule
